@@ hdl/tsu_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the tandem repeat scanner
// no dependencies
package tsu_pkg;

  localparam int unsigned MAX_MOTIF_DEF  = 8;
  localparam int unsigned POS_BITS_DEF   = 32;
  localparam int unsigned K_W            = 4;
  localparam int unsigned MIN_SPAN_W     = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned OUT_POS_W      = 32;
  localparam int unsigned OUT_CNT_W      = 32;
  localparam int unsigned OUT_MOTIF_W    = 16;
  localparam int unsigned RES_FIFO_DEPTH = 8;

  localparam logic [K_W-1:0]        MOTIF_LEN_RST = 4'd7;
  localparam logic [MIN_SPAN_W-1:0] MIN_SPAN_RST  = 16'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTIF_LENGTH = 1'b0,
    REG_MIN_SPAN     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [OUT_POS_W-1:0]   start_position;
    logic [OUT_CNT_W-1:0]   repeat_count;
    logic [OUT_MOTIF_W-1:0] motif_code;
    logic                   last_result;
  } result_t;

  typedef struct packed {
    logic    vld_a;
    logic    vld_b;
    result_t res_a;
    result_t res_b;
  } push_t;

endpackage

@@ hdl/tsu_stream_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel bundles for base beats and result beats
// depends on tsu_pkg
interface tsu_base_if import tsu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] base_code;
  logic       final_base;

  modport source (output valid, output base_code, output final_base, input ready);
  modport sink (input valid, input base_code, input final_base, output ready);
endinterface

interface tsu_result_if import tsu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_POS_W-1:0]   start_position;
  logic [OUT_CNT_W-1:0]   repeat_count;
  logic [OUT_MOTIF_W-1:0] motif_code;
  logic                   last_result;

  modport source (
    output valid, output start_position, output repeat_count,
    output motif_code, output last_result, input ready
  );
  modport sink (
    input valid, input start_position, input repeat_count,
    input motif_code, input last_result, output ready
  );
endinterface

@@ hdl/tsu_occ_mem.sv @@
`timescale 1ns / 1ps
// occurrence table: one write port, one registered read port, clearing sweep after reset
// depends on tsu_pkg
module tsu_occ_mem import tsu_pkg::*; #(
  parameter int unsigned ADDR_W = 2 * MAX_MOTIF_DEF,
  parameter int unsigned DATA_W = POS_BITS_DEF + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              clr_busy_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [ADDR_W:0]   clr_cnt_q;

  assign clr_busy_o = ~clr_cnt_q[ADDR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy_o) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_o) begin
      mem_q[clr_cnt_q[ADDR_W-1:0]] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ hdl/tsu_out_fifo.sv @@
`timescale 1ns / 1ps
// result queue taking up to two beats per cycle and giving one
// depends on tsu_pkg
module tsu_out_fifo import tsu_pkg::*; #(
  parameter int unsigned DEPTH = RES_FIFO_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    valid_o,
  output result_t data_o,
  output logic    room_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  result_t          buf_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, slot_b;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = buf_q[rd_ptr_q];
  // one slot-pair for the beat in flight and one for the next beat
  assign room_o  = cnt_q <= CNT_W'(DEPTH - 4);
  assign do_pop  = pop_i & valid_o;
  assign slot_b  = wr_ptr_q + PTR_W'(push_i.vld_a);
  assign cnt_d   = cnt_q + CNT_W'(push_i.vld_a) + CNT_W'(push_i.vld_b) - CNT_W'(do_pop);

  always_ff @(posedge clk_i) begin
    if (push_i.vld_a) begin
      buf_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.vld_b) begin
      buf_q[slot_b] <= push_i.res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_i.vld_a) + PTR_W'(push_i.vld_b);
      rd_ptr_q <= rd_ptr_q + PTR_W'(do_pop);
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hdl/tandem_repeat_scanner_unit.sv @@
`timescale 1ns / 1ps
// tandem repeat scanner top level; depends on tsu_pkg, tsu_stream_if, tsu_occ_mem, tsu_out_fifo
// throughput: one base beat per cycle while ready is high; the table read in stage 0 and the
// write-back in stage 1 forward the previous write, so back-to-back hits on one k-mer do not stall
// results: a result beat is formed in stage 1 and waits in the output queue until it is taken
// ready drops while more than four result beats wait in the output queue
// reset: the occurrence table is swept clear, all 2**(2*MAX_MOTIF) entries (65536 by default),
// with ready low; configuration writes are taken during the sweep
module tandem_repeat_scanner_unit import tsu_pkg::*; #(
  parameter int unsigned MAX_MOTIF     = MAX_MOTIF_DEF,
  parameter int unsigned POSITION_BITS = POS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tsu_base_if.sink              base_i,
  tsu_result_if.source          result_o
);

  localparam int unsigned IDX_W   = 2 * MAX_MOTIF;
  localparam int unsigned ENTRY_W = POSITION_BITS + 2;
  localparam int unsigned SPAN_W  = OUT_CNT_W + K_W;
  localparam int unsigned END_W   = ((POSITION_BITS > SPAN_W) ? POSITION_BITS : SPAN_W) + 1;

  // configuration
  logic [K_W-1:0]        motif_len_q;
  logic [MIN_SPAN_W-1:0] min_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motif_len_q <= MOTIF_LEN_RST;
      min_span_q  <= MIN_SPAN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MOTIF_LENGTH: motif_len_q <= cfg_data_i[K_W-1:0];
        REG_MIN_SPAN:     min_span_q  <= cfg_data_i[MIN_SPAN_W-1:0];
        default:          ;
      endcase
    end
  end

  logic [K_W-1:0]   k_eff;
  logic [IDX_W-1:0] kmask;

  always_comb begin
    k_eff = motif_len_q;
    if (motif_len_q == '0) begin
      k_eff = K_W'(1);
    end else if (motif_len_q > K_W'(MAX_MOTIF)) begin
      k_eff = K_W'(MAX_MOTIF);
    end
    for (int j = 0; j < int'(MAX_MOTIF); j++) begin
      kmask[2*j +: 2] = {2{j < int'(k_eff)}};
    end
  end

  // stage 0: window update and table read
  logic                     clr_busy, fifo_room, in_acc;
  logic [IDX_W-1:0]         win_q, win_d;
  logic [K_W-1:0]           fill_q, fill_d;
  logic [POSITION_BITS-1:0] pos_q;
  logic                     scan_d;

  assign base_i.ready = ~clr_busy & fifo_room;
  assign in_acc       = base_i.valid & base_i.ready;
  assign win_d        = IDX_W'({win_q, base_i.base_code}) & kmask;
  assign fill_d       = (fill_q < K_W'(MAX_MOTIF)) ? fill_q + 1'b1 : fill_q;
  assign scan_d       = fill_d >= k_eff;

  logic                     s1_vld_q, s1_scan_q, s1_fin_q;
  logic [IDX_W-1:0]         s1_idx_q;
  logic [POSITION_BITS-1:0] s1_pos_q;
  logic [K_W-1:0]           s1_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      fill_q   <= '0;
      pos_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
      if (in_acc) begin
        win_q  <= win_d;
        fill_q <= fill_d;
        if (scan_d) begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_scan_q <= scan_d;
      s1_fin_q  <= base_i.final_base;
      s1_idx_q  <= win_d;
      s1_pos_q  <= pos_q;
      s1_k_q    <= k_eff;
    end
  end

  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wd, mem_rd;

  tsu_occ_mem #(
    .ADDR_W (IDX_W),
    .DATA_W (ENTRY_W)
  ) u_occ_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_acc & scan_d),
    .rd_addr_i  (win_d),
    .rd_data_o  (mem_rd),
    .wr_en_i    (mem_we),
    .wr_addr_i  (s1_idx_q),
    .wr_data_i  (mem_wd),
    .clr_busy_o (clr_busy)
  );

  // stage 1: resolve entry, update record, write back
  logic               fwd_vld_q;
  logic [IDX_W-1:0]   fwd_addr_q;
  logic [ENTRY_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= s1_idx_q;
    fwd_data_q <= mem_wd;
  end

  logic [ENTRY_W-1:0]       entry;
  logic [POSITION_BITS-1:0] last, gap;
  logic                     seen, run, hit, blocked, rec_long;
  logic [END_W-1:0]         lhs, rec_end;

  logic [POSITION_BITS-1:0] rec_start_q, rec_start_d;
  logic [OUT_CNT_W-1:0]     rec_count_q, rec_count_d;
  logic [IDX_W-1:0]         rec_motif_q, rec_motif_d;
  logic [SPAN_W-1:0]        rec_span_q, rec_span_d;
  logic                     rec_vld_q, rec_vld_mid, rec_vld_d;
  logic                     emit_a, emit_b;
  push_t                    push;

  assign entry    = (fwd_vld_q && fwd_addr_q == s1_idx_q) ? fwd_data_q : mem_rd;
  assign last     = entry[POSITION_BITS-1:0];
  assign seen     = entry[POSITION_BITS];
  assign run      = entry[POSITION_BITS+1];
  assign gap      = s1_pos_q - last;
  assign hit      = gap == POSITION_BITS'(s1_k_q);
  assign lhs      = END_W'(last) + END_W'(s1_k_q);
  assign rec_end  = END_W'(rec_start_q) + END_W'(rec_span_q);
  assign blocked  = rec_vld_q && (lhs < rec_end) && (s1_idx_q != rec_motif_q);
  assign rec_long = rec_vld_q && (rec_span_q >= SPAN_W'(min_span_q));

  always_comb begin
    mem_we      = 1'b0;
    mem_wd      = {1'b0, 1'b1, s1_pos_q};
    emit_a      = 1'b0;
    rec_start_d = rec_start_q;
    rec_count_d = rec_count_q;
    rec_motif_d = rec_motif_q;
    rec_span_d  = rec_span_q;
    rec_vld_mid = rec_vld_q;
    if (s1_vld_q && s1_scan_q) begin
      mem_we = 1'b1;
      if (seen && hit && !blocked) begin
        mem_wd = {1'b1, 1'b1, s1_pos_q};
        if (!run) begin
          emit_a      = rec_long;
          rec_start_d = last;
          rec_count_d = OUT_CNT_W'(2);
          rec_motif_d = s1_idx_q;
          rec_span_d  = SPAN_W'(s1_k_q) << 1;
          rec_vld_mid = 1'b1;
        end else begin
          if (rec_count_q != '1) begin
            rec_count_d = rec_count_q + 1'b1;
          end
          rec_span_d = SPAN_W'(rec_count_d) * SPAN_W'(s1_k_q);
        end
      end
    end
    emit_b    = s1_vld_q && s1_fin_q && rec_vld_mid
                && (rec_span_d >= SPAN_W'(min_span_q));
    rec_vld_d = rec_vld_mid && !(s1_vld_q && s1_fin_q);
  end

  always_comb begin
    push.vld_a                = emit_a;
    push.vld_b                = emit_b;
    push.res_a.start_position = OUT_POS_W'(rec_start_q);
    push.res_a.repeat_count   = rec_count_q;
    push.res_a.motif_code     = OUT_MOTIF_W'(rec_motif_q);
    push.res_a.last_result    = ~emit_b;
    push.res_b.start_position = OUT_POS_W'(rec_start_d);
    push.res_b.repeat_count   = rec_count_d;
    push.res_b.motif_code     = OUT_MOTIF_W'(rec_motif_d);
    push.res_b.last_result    = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_start_q <= '0;
      rec_count_q <= '0;
      rec_motif_q <= '0;
      rec_span_q  <= '0;
      rec_vld_q   <= 1'b0;
    end else begin
      rec_start_q <= rec_start_d;
      rec_count_q <= rec_count_d;
      rec_motif_q <= rec_motif_d;
      rec_span_q  <= rec_span_d;
      rec_vld_q   <= rec_vld_d;
    end
  end

  // result queue
  result_t fifo_data;
  logic    fifo_valid;

  tsu_out_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (result_o.ready),
    .valid_o (fifo_valid),
    .data_o  (fifo_data),
    .room_o  (fifo_room)
  );

  assign result_o.valid          = fifo_valid;
  assign result_o.start_position = fifo_data.start_position;
  assign result_o.repeat_count   = fifo_data.repeat_count;
  assign result_o.motif_code     = fifo_data.motif_code;
  assign result_o.last_result    = fifo_data.last_result;

endmodule

@@ hdl/tsu_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the tandem repeat scanner, bound to the top level
// depends on tsu_pkg and tandem_repeat_scanner_unit
module tsu_checker import tsu_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_i,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic [OUT_POS_W-1:0]   res_start_i,
  input logic [OUT_CNT_W-1:0]   res_count_i,
  input logic [OUT_MOTIF_W-1:0] res_motif_i,
  input logic                   res_last_i
);

  // stalled result beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  // stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable({res_start_i, res_count_i, res_motif_i, res_last_i}))
    else $error("result payload changed while stalled");

  // a reported repeat always has at least two copies
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_count_i >= OUT_CNT_W'(2))
    else $error("repeat count below two");

  // table sweep holds off input right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i)
    else $error("input ready during table sweep");

endmodule

bind tandem_repeat_scanner_unit tsu_checker u_tsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (base_i.ready),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_start_i (result_o.start_position),
  .res_count_i (result_o.repeat_count),
  .res_motif_i (result_o.motif_code),
  .res_last_i  (result_o.last_result)
);
